/* rtl/ckh_pkg.sv */
// Shared types and constants for the canonical k-mer hash unit.
package ckh_pkg;

  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] H1_ADD = 64'h0000000052dce729;
  localparam logic [63:0] H2_ADD = 64'h0000000038495ab5;

  localparam logic REG_KMER_LENGTH = 1'b0;
  localparam logic REG_CANONICAL = 1'b1;

  // Payload of the input channel.
  typedef struct packed {
    logic [7:0] base;
    logic       start_req;
  } kmer_in_t;

  // Datapath operations, one per controller step. The multiplying operations
  // work on one lane and take three steps each.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_SHIFT   = 4'd1,  // take in a byte, build k-mer strings
    OP_COMPARE = 4'd2,  // pick window or reverse complement
    OP_LOAD    = 4'd3,  // load k1/k2 of the current block
    OP_MUL_A   = 4'd4,  // k *= c_a, rotate
    OP_MUL_B   = 4'd5,  // k *= c_b, mix into h
    OP_MIX     = 4'd6,  // h rotate, add, *5 (block only)
    OP_FIN_ADD = 4'd7,  // length xor and cross add
    OP_FMIX_A  = 4'd8,  // shift xor, multiply by first constant
    OP_FMIX_B  = 4'd9,  // shift xor, multiply by second constant
    OP_FMIX_C  = 4'd10, // last shift xor
    OP_RESULT  = 4'd11  // h1 + h2 into output register
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] blk;    // block index 0..3 (16 bytes each)
    logic       lane;   // 0: k1/h1, 1: k2/h2
    logic [1:0] step;   // partial product step of a multiply
  } dp_cmd_t;

  typedef struct packed {
    logic       emit;     // window holds at least k bytes
    logic [2:0] nblocks;  // full 16-byte blocks
    logic       has_tail;
  } dp_status_t;

  function automatic logic [7:0] complement(input logic [7:0] c);
    case (c)
      8'h41: complement = 8'h54;
      8'h54: complement = 8'h41;
      8'h43: complement = 8'h47;
      8'h47: complement = 8'h43;
      8'h61: complement = 8'h74;
      8'h74: complement = 8'h61;
      8'h63: complement = 8'h67;
      8'h67: complement = 8'h63;
      default: complement = 8'h4e;
    endcase
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

endpackage

/* rtl/ckh_stream_if.sv */
// Valid/ready channel interface carrying a generic payload.
interface ckh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ckh_ctrl.sv */
// Controller state machine sequencing the hash datapath.
module ckh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ckh_pkg::dp_status_t status,
  output ckh_pkg::dp_cmd_t  cmd
);
  import ckh_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_COMPARE = 11'b00000000010,
    S_LOAD    = 11'b00000000100,
    S_MUL_A   = 11'b00000001000,
    S_MUL_B   = 11'b00000010000,
    S_MIX     = 11'b00000100000,
    S_FIN     = 11'b00001000000,
    S_FMIX_A  = 11'b00010000000,
    S_FMIX_B  = 11'b00100000000,
    S_FMIX_C  = 11'b01000000000,
    S_RESULT  = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] blk, blk_next;
  logic       tail, tail_next;
  logic       half, half_next;   // 0: k1 lane, 1: k2 lane
  logic [1:0] step, step_next;   // multiply step, 0..2
  logic       pend, pend_next;   // result held in output register

  assign in_ready = (state == S_IDLE) && !pend;
  assign out_valid = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      blk <= '0;
      tail <= 1'b0;
      half <= 1'b0;
      step <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      blk <= blk_next;
      tail <= tail_next;
      half <= half_next;
      step <= step_next;
      pend <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    blk_next = blk;
    tail_next = tail;
    half_next = half;
    step_next = step;
    pend_next = pend && !out_ready;
    cmd.op = OP_NONE;
    cmd.blk = blk;
    cmd.lane = half;
    cmd.step = step;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op = OP_SHIFT;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.op = OP_COMPARE;
        blk_next = '0;
        half_next = 1'b0;
        if (!status.emit) begin
          state_next = S_IDLE;
        end else if (status.nblocks != 3'd0) begin
          tail_next = 1'b0;
          state_next = S_LOAD;
        end else if (status.has_tail) begin
          tail_next = 1'b1;
          state_next = S_LOAD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_LOAD: begin
        cmd.op = OP_LOAD;
        half_next = 1'b0;
        state_next = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.op = OP_MUL_A;
        if (step == 2'd2) begin
          step_next = '0;
          state_next = S_MUL_B;
        end else begin
          step_next = step + 2'd1;
        end
      end
      S_MUL_B: begin
        cmd.op = OP_MUL_B;
        if (step == 2'd2) begin
          step_next = '0;
          if (!tail) begin
            state_next = S_MIX;
          end else if (!half) begin
            half_next = 1'b1;
            state_next = S_MUL_A;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          step_next = step + 2'd1;
        end
      end
      S_MIX: begin
        cmd.op = OP_MIX;
        if (!half) begin
          half_next = 1'b1;
          state_next = S_MUL_A;
        end else if ({1'b0, blk} + 3'd1 < status.nblocks) begin
          blk_next = blk + 2'd1;
          state_next = S_LOAD;
        end else if (status.has_tail) begin
          blk_next = blk + 2'd1;
          tail_next = 1'b1;
          state_next = S_LOAD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op = OP_FIN_ADD;
        half_next = 1'b0;
        state_next = S_FMIX_A;
      end
      S_FMIX_A: begin
        cmd.op = OP_FMIX_A;
        if (step == 2'd2) begin
          step_next = '0;
          state_next = S_FMIX_B;
        end else begin
          step_next = step + 2'd1;
        end
      end
      S_FMIX_B: begin
        cmd.op = OP_FMIX_B;
        if (step == 2'd2) begin
          step_next = '0;
          if (!half) begin
            half_next = 1'b1;
            state_next = S_FMIX_A;
          end else begin
            state_next = S_FMIX_C;
          end
        end else begin
          step_next = step + 2'd1;
        end
      end
      S_FMIX_C: begin
        cmd.op = OP_FMIX_C;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        cmd.op = OP_RESULT;
        pend_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/ckh_datapath.sv */
// Window shift line, canonical selection and MurmurHash3 arithmetic.
module ckh_datapath #(
  parameter int MaxKmer = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       base,
  input  logic             start_req,
  input  logic [5:0]       kmer_length,
  input  logic             canonical_mode,
  input  ckh_pkg::dp_cmd_t cmd,
  output ckh_pkg::dp_status_t status,
  output logic [63:0]      hash_value
);
  import ckh_pkg::*;

  localparam int FW = $clog2(MaxKmer + 1);

  logic [7:0]    win [MaxKmer];
  logic [FW-1:0] fill;
  logic [7:0]    fwd [MaxKmer];  // k-mer, byte 0 first, zero padded
  logic [7:0]    rev [MaxKmer];
  logic [6:0]    klen;
  logic [63:0]   k1, k2, h1, h2;
  logic [6:0]    kk;
  logic [FW-1:0] kmax;
  logic          rev_less;
  logic [63:0]   ld1, ld2, mix1, mix2;
  logic [63:0]   mul_a, mul_b, mul_p, mul_res, acc;
  logic [31:0]   mul_x, mul_y;

  // Effective length after clamping.
  always_comb begin
    kk = {1'b0, kmer_length};
    if (kk == 7'd0) kk = 7'd1;
    if (kk > 7'(MaxKmer)) kk = 7'(MaxKmer);
    kmax = FW'(kk);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.op == OP_SHIFT) begin
      if (start_req) fill <= FW'(1);
      else if (fill < FW'(MaxKmer)) fill <= fill + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SHIFT) begin
      for (int i = 0; i < MaxKmer - 1; i++) win[i] <= win[i+1];
      win[MaxKmer-1] <= base;
    end
  end

  // Lexicographic compare from first byte: first differing byte decides.
  always_comb begin
    rev_less = 1'b0;
    for (int i = MaxKmer - 1; i >= 0; i--) begin
      if (i < int'(klen) && rev[i] != fwd[i]) rev_less = rev[i] < fwd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SHIFT) begin
      klen <= kk;
      for (int i = 0; i < MaxKmer; i++) begin
        if (i < int'(kk)) begin
          fwd[i] <= win[MaxKmer - int'(kk) + i + ((i == int'(kk) - 1) ? 0 : 1)];
          rev[i] <= complement(i == 0 ? base : win[MaxKmer - i]);
        end else begin
          fwd[i] <= 8'h00;
          rev[i] <= 8'h00;
        end
      end
      // newest byte is base; window entries shift by one at this edge
      fwd[int'(kk) - 1] <= base;
    end else if (cmd.op == OP_COMPARE && canonical_mode && rev_less) begin
      for (int i = 0; i < MaxKmer; i++) fwd[i] <= rev[i];
    end
  end

  assign status.emit = fill >= kmax;
  assign status.nblocks = 3'(klen >> 4);
  assign status.has_tail = klen[3:0] != 4'd0;

  // Block bytes; tail bytes beyond k are zero thanks to padding.
  always_comb begin
    ld1 = '0;
    ld2 = '0;
    for (int b = 0; b < 8; b++) begin
      if (int'(cmd.blk) * 16 + b < MaxKmer)
        ld1[b*8 +: 8] = fwd[int'(cmd.blk) * 16 + b];
      if (int'(cmd.blk) * 16 + 8 + b < MaxKmer)
        ld2[b*8 +: 8] = fwd[int'(cmd.blk) * 16 + 8 + b];
    end
    mix1 = rotl(h1, 6'd27) + h2;
    mix2 = rotl(h2, 6'd31) + h1;
  end

  // One shared 32x32 multiplier builds the low 64 bits of a product over
  // three steps: low x low, then the two cross terms shifted up by 32.
  always_comb begin
    mul_a = cmd.lane ? k2 : k1;
    mul_b = cmd.lane ? MM_C2 : MM_C1;
    case (cmd.op)
      OP_MUL_B: mul_b = cmd.lane ? MM_C1 : MM_C2;
      OP_FMIX_A: begin
        mul_a = cmd.lane ? (h2 ^ (h2 >> 33)) : (h1 ^ (h1 >> 33));
        mul_b = FMIX_M1;
      end
      OP_FMIX_B: begin
        mul_a = cmd.lane ? (h2 ^ (h2 >> 33)) : (h1 ^ (h1 >> 33));
        mul_b = FMIX_M2;
      end
      default: ;
    endcase
    mul_x = (cmd.step == 2'd2) ? mul_a[63:32] : mul_a[31:0];
    mul_y = (cmd.step == 2'd1) ? mul_b[63:32] : mul_b[31:0];
    mul_p = 64'(mul_x) * 64'(mul_y);
    mul_res = acc + {mul_p[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (cmd.step == 2'd0) acc <= mul_p;
    else acc <= mul_res;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_COMPARE: begin
        h1 <= '0;
        h2 <= '0;
      end
      OP_LOAD: begin
        k1 <= ld1;
        k2 <= ld2;
      end
      OP_MUL_A: begin
        if (cmd.step == 2'd2) begin
          if (!cmd.lane) k1 <= rotl(mul_res, 6'd31);
          else k2 <= rotl(mul_res, 6'd33);
        end
      end
      OP_MUL_B: begin
        if (cmd.step == 2'd2) begin
          if (!cmd.lane) h1 <= h1 ^ mul_res;
          else h2 <= h2 ^ mul_res;
        end
      end
      OP_MIX: begin
        if (!cmd.lane) h1 <= (mix1 << 2) + mix1 + H1_ADD;
        else h2 <= (mix2 << 2) + mix2 + H2_ADD;
      end
      OP_FIN_ADD: begin
        h1 <= (h1 ^ 64'(klen)) + (h2 ^ 64'(klen));
        h2 <= (h2 ^ 64'(klen)) + (h1 ^ 64'(klen)) + (h2 ^ 64'(klen));
      end
      OP_FMIX_A, OP_FMIX_B: begin
        if (cmd.step == 2'd2) begin
          if (!cmd.lane) h1 <= mul_res;
          else h2 <= mul_res;
        end
      end
      OP_FMIX_C: begin
        h1 <= h1 ^ (h1 >> 33);
        h2 <= h2 ^ (h2 >> 33);
      end
      OP_RESULT: hash_value <= h1 + h2;
      default: ;
    endcase
  end
endmodule

/* rtl/canonical_kmer_hash64_unit.sv */
// Top level of the canonical k-mer MurmurHash3 unit.
//
//  channel   dir   payload                     handshake
//  in_ch     in    base[8], start_req[1]       valid/ready
//  out_ch    out   hash_value[64]              valid/ready
//  cfg       in    cfg_we, cfg_index, cfg_data write enable only
//
// A byte that completes no k-mer frees the input once intake and compare are
// done. Otherwise the word is offered after intake and compare, one pass per
// full 16-byte block, a tail pass when k is not a multiple of 16, and
// finalization. Each 64-bit multiply is built from partial products on one
// shared 32x32 multiplier. Reset clears the fill count and the controller;
// registers go to k=16, canonical mode on. A finished word waits in the
// output register; a new byte is taken only once it has been delivered.
module canonical_kmer_hash64_unit #(
  parameter int MAX_KMER = 32
) (
  input  logic       clk,
  input  logic       rst,
  ckh_stream_if.sink   in_ch,
  ckh_stream_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);
  import ckh_pkg::*;

  logic [5:0] kmer_length;
  logic       canonical_mode;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [63:0] hash_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= 6'd16;
      canonical_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KMER_LENGTH: kmer_length <= cfg_data;
        REG_CANONICAL:   canonical_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ckh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .cmd(cmd)
  );

  ckh_datapath #(.MaxKmer(MAX_KMER)) u_dp (
    .clk(clk), .rst(rst),
    .base(in_ch.data.base), .start_req(in_ch.data.start_req),
    .kmer_length(kmer_length), .canonical_mode(canonical_mode),
    .cmd(cmd), .status(status), .hash_value(hash_value)
  );

  assign out_ch.data = hash_value;
endmodule
